### design/adc_pkg.sv
// shared types and constants for the adjacent duplicate compactor
// lane count, word width, the lane types used by every module and the control type
// no dependencies
`timescale 1ns / 1ps

package adc_pkg;

   localparam int LANES  = 8;
   localparam int WORD_W = 32;
   localparam int CNT_W  = 4;

   typedef logic [WORD_W-1:0]          word_type;
   typedef word_type [LANES-1:0]       lanes_type;
   typedef logic [LANES-1:0]           mask_type;
   typedef logic [CNT_W-1:0]           count_type;

   // control of the input register toward the keep logic
   typedef struct packed {
      logic      advance;      // word group moves on to the result register
      count_type lane_count;
      logic      start;
   } stage_ctl_type;

endpackage

### design/adjacent_duplicate_compactor_x8_top.sv
// top level of the adjacent duplicate compactor; instantiates adc_keep and adc_pack
// depends on adc_pkg
`timescale 1ns / 1ps

// Takes one group of eight words per cycle while req_stall is low and returns one packed
// result per group: an input register, then compare and pack logic, then the result
// register. Throughput is one group per clock without stalls; the only history carried
// from group to group is the last valid word, which updates as a group leaves the
// input register, so back-to-back groups see their true predecessor. A stalled
// result holds both registers, and req_stall follows rsp_stall in the same cycle
// once both registers are full. An empty group (lane count zero) yields a zero
// count and leaves the history unchanged; lane counts above eight saturate.
module adjacent_duplicate_compactor_x8_top import adc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value_0,
   input  logic [31:0] req_value_1,
   input  logic [31:0] req_value_2,
   input  logic [31:0] req_value_3,
   input  logic [31:0] req_value_4,
   input  logic [31:0] req_value_5,
   input  logic [31:0] req_value_6,
   input  logic [31:0] req_value_7,
   input  logic [3:0]  req_lane_count,
   input  logic        req_start_of_array,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_kept_0,
   output logic [31:0] rsp_kept_1,
   output logic [31:0] rsp_kept_2,
   output logic [31:0] rsp_kept_3,
   output logic [31:0] rsp_kept_4,
   output logic [31:0] rsp_kept_5,
   output logic [31:0] rsp_kept_6,
   output logic [31:0] rsp_kept_7,
   output logic [3:0]  rsp_kept_count
);

   lanes_type     req_words;
   logic          s1_valid_ff, s1_valid_in;
   lanes_type     s1_words_ff;
   count_type     s1_count_ff;
   logic          s1_start_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   lanes_type     rsp_kept_ff;
   count_type     rsp_count_ff;
   logic          rsp_load;
   logic          s1_load;
   stage_ctl_type ctl;
   mask_type      keep;
   lanes_type     kept;
   count_type     kept_count;

   assign req_words = {req_value_7, req_value_6, req_value_5, req_value_4,
                       req_value_3, req_value_2, req_value_1, req_value_0};

   // result register takes a word group whenever it is empty or being drained
   assign rsp_load  = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !rsp_load;
   assign s1_load   = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_load || (s1_valid_ff && !rsp_load);
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   assign ctl.advance    = rsp_load;
   assign ctl.lane_count = s1_count_ff;
   assign ctl.start      = s1_start_ff;

   adc_keep u_keep (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .words (s1_words_ff),
      .keep  (keep)
   );

   adc_pack u_pack (
      .words      (s1_words_ff),
      .keep       (keep),
      .kept       (kept),
      .kept_count (kept_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_words_ff <= req_words;
         s1_count_ff <= req_lane_count;
         s1_start_ff <= req_start_of_array;
      end
      if (rsp_load) begin
         rsp_kept_ff  <= kept;
         rsp_count_ff <= kept_count;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kept_0     = rsp_kept_ff[0];
   assign rsp_kept_1     = rsp_kept_ff[1];
   assign rsp_kept_2     = rsp_kept_ff[2];
   assign rsp_kept_3     = rsp_kept_ff[3];
   assign rsp_kept_4     = rsp_kept_ff[4];
   assign rsp_kept_5     = rsp_kept_ff[5];
   assign rsp_kept_6     = rsp_kept_ff[6];
   assign rsp_kept_7     = rsp_kept_ff[7];
   assign rsp_kept_count = rsp_count_ff;

   // input side only stalls behind a full input register
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall raised with an empty input register");

   // a group leaving the input register is in the result register next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid)
      else $error("loaded result not shown");

   // no lane is kept beyond the valid lanes, so an empty group keeps nothing
   a_empty_keeps_none: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_count_ff == '0)) |-> (keep == '0))
      else $error("lane kept in an empty group");

   // a zero count leaves the first slot zero
   a_zero_count_zero_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kept_count == '0)) |-> (rsp_kept_0 == '0))
      else $error("nonzero word with zero kept count");

endmodule

### design/adc_keep.sv
// keep mask: compares every valid lane with its predecessor in stream order
// holds the last word of the previous group; depends on adc_pkg
`timescale 1ns / 1ps

module adc_keep import adc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl,
   input  lanes_type     words,
   output mask_type      keep
);

   word_type  prev_word_ff, prev_word_in;
   logic      prev_valid_ff, prev_valid_in;
   count_type count_sat;
   mask_type  lane_valid;
   word_type  last_word;

   always_comb begin
      if (ctl.lane_count > CNT_W'(LANES)) begin
         count_sat = CNT_W'(LANES);
      end else begin
         count_sat = ctl.lane_count;
      end

      last_word = prev_word_ff;
      for (int i = 0; i < LANES; i++) begin
         lane_valid[i] = (CNT_W'(i) < count_sat);
         if (lane_valid[i]) begin
            last_word = words[i];
         end
      end

      keep[0] = lane_valid[0] &&
                (ctl.start || !prev_valid_ff || (words[0] != prev_word_ff));
      for (int i = 1; i < LANES; i++) begin
         keep[i] = lane_valid[i] && (words[i] != words[i-1]);
      end

      // an empty group leaves the history alone
      prev_word_in  = prev_word_ff;
      prev_valid_in = prev_valid_ff;
      if (ctl.advance && lane_valid[0]) begin
         prev_word_in  = last_word;
         prev_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_word_ff  <= '0;
         prev_valid_ff <= 1'b0;
      end else begin
         prev_word_ff  <= prev_word_in;
         prev_valid_ff <= prev_valid_in;
      end
   end

endmodule

### design/adc_pack.sv
// packs the kept lanes toward lane 0 and counts them; dropped slots read zero
// purely combinational; depends on adc_pkg
`timescale 1ns / 1ps

module adc_pack import adc_pkg::*; (
   input  lanes_type words,
   input  mask_type  keep,
   output lanes_type kept,
   output count_type kept_count
);

   count_type pos [LANES+1];

   always_comb begin
      // slot of each lane in the packed result
      pos[0] = '0;
      for (int i = 0; i < LANES; i++) begin
         pos[i+1] = pos[i] + CNT_W'(keep[i]);
      end
      kept_count = pos[LANES];

      for (int k = 0; k < LANES; k++) begin
         kept[k] = '0;
         for (int i = 0; i < LANES; i++) begin
            if (keep[i] && (pos[i] == CNT_W'(k))) begin
               kept[k] = kept[k] | words[i];
            end
         end
      end
   end

endmodule

### tb/adjacent_duplicate_compactor_x8_top_tb.sv
// self-checking testbench for adjacent_duplicate_compactor_x8_top: directed and random word
// groups, random request gaps and result stalls, each result checked against a local predictor
// depends on adc_pkg and the adjacent_duplicate_compactor_x8_top design files
`timescale 1ns / 1ps

module adjacent_duplicate_compactor_x8_top_tb;
   import adc_pkg::*;

   localparam int RANDOM_GROUPS = 1750;
   localparam int IDLE_LIMIT    = 5000;
   localparam int DRAIN_CYCLES  = 8;

   typedef struct {
      lanes_type value;
      count_type lane_count;
      logic      start;
   } group_type;

   typedef struct {
      lanes_type kept;
      count_type count;
   } compaction_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_value_0, req_value_1, req_value_2, req_value_3;
   logic [31:0] req_value_4, req_value_5, req_value_6, req_value_7;
   logic [3:0]  req_lane_count;
   logic        req_start_of_array;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_kept_0, rsp_kept_1, rsp_kept_2, rsp_kept_3;
   logic [31:0] rsp_kept_4, rsp_kept_5, rsp_kept_6, rsp_kept_7;
   logic [3:0]  rsp_kept_count;

   group_type      pending_groups[$];
   compaction_type due_compactions[$];

   // predictor history: last valid lane value seen
   word_type history_word  = '0;
   logic     history_valid = 1'b0;

   int unsigned groups_queued      = 0;
   int unsigned groups_accepted    = 0;
   int unsigned results_checked    = 0;
   int unsigned empty_groups       = 0;
   int unsigned saturated_groups   = 0;
   int unsigned duplicates_removed = 0;
   int unsigned mismatches         = 0;
   int unsigned idle_cycles        = 0;
   int unsigned req_gap            = 0;
   int unsigned stall_left         = 0;
   bit          word_taken         = 1'b0;
   bit          req_calm           = 1'b0;
   bit          rsp_calm           = 1'b0;

   adjacent_duplicate_compactor_x8_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_value_0        (req_value_0),
      .req_value_1        (req_value_1),
      .req_value_2        (req_value_2),
      .req_value_3        (req_value_3),
      .req_value_4        (req_value_4),
      .req_value_5        (req_value_5),
      .req_value_6        (req_value_6),
      .req_value_7        (req_value_7),
      .req_lane_count     (req_lane_count),
      .req_start_of_array (req_start_of_array),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kept_0         (rsp_kept_0),
      .rsp_kept_1         (rsp_kept_1),
      .rsp_kept_2         (rsp_kept_2),
      .rsp_kept_3         (rsp_kept_3),
      .rsp_kept_4         (rsp_kept_4),
      .rsp_kept_5         (rsp_kept_5),
      .rsp_kept_6         (rsp_kept_6),
      .rsp_kept_7         (rsp_kept_7),
      .rsp_kept_count     (rsp_kept_count)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // drops each lane value equal to its predecessor and packs the rest from lane 0
   function automatic compaction_type compact_group(input group_type g);
      compaction_type r;
      int unsigned    n;
      bit             keep;
      r.kept  = '0;
      r.count = '0;
      n = (g.lane_count > LANES) ? LANES : g.lane_count;
      for (int i = 0; i < n; i++) begin
         if (i == 0)
            keep = g.start || !history_valid || g.value[0] != history_word;
         else
            keep = g.value[i] != g.value[i-1];
         if (keep) begin
            r.kept[r.count[2:0]] = g.value[i];
            r.count++;
         end
      end
      if (n > 0) begin
         history_word  = g.value[n-1];
         history_valid = 1'b1;
      end
      duplicates_removed += n - r.count;
      return r;
   endfunction

   function automatic int unsigned pick_gap(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // often equal steps so runs of duplicates form, now and then a jump anywhere
   function automatic word_type next_step();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return '0;
      if (r < 85)
         return $urandom_range(1, 3);
      return $urandom();
   endfunction

   task automatic queue_group(input lanes_type v, input int unsigned lc, input logic s);
      group_type g;
      g.value      = v;
      g.lane_count = CNT_W'(lc);
      g.start      = s;
      pending_groups.push_back(g);
      groups_queued++;
   endtask

   // an array of stepped (wrapping) values spread over up to sixteen groups, junk in unused lanes
   task automatic queue_sorted_run();
      lanes_type   v;
      word_type    w;
      int unsigned groups;
      int unsigned lc;
      groups = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 4);
      w = $urandom();
      for (int k = 0; k < groups; k++) begin
         lc = (k == groups - 1 && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : LANES;
         if ($urandom_range(0, 15) == 0)
            lc = 0;
         for (int i = 0; i < LANES; i++) begin
            if (i < lc) begin
               v[i] = w;
               w    = w + next_step();
            end else begin
               v[i] = ($urandom_range(0, 1) == 0) ? w : $urandom();
            end
         end
         queue_group(v, lc, k == 0 && $urandom_range(0, 19) != 0);
      end
   endtask

   // unstructured group: any lane count the field allows, values from a tiny pool or random
   task automatic queue_noise_group();
      lanes_type v;
      word_type  pool[4];
      for (int i = 0; i < 4; i++)
         pool[i] = $urandom();
      for (int i = 0; i < LANES; i++)
         v[i] = ($urandom_range(0, 1) == 0) ? pool[2'($urandom_range(0, 3))] : $urandom();
      queue_group(v, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic check_result();
      compaction_type want;
      lanes_type      got;
      if (due_compactions.size() == 0) begin
         report_mismatch($sformatf("result with no group outstanding, kept_count %0d",
                                   rsp_kept_count));
         return;
      end
      want = due_compactions.pop_front();
      got  = {rsp_kept_7, rsp_kept_6, rsp_kept_5, rsp_kept_4,
              rsp_kept_3, rsp_kept_2, rsp_kept_1, rsp_kept_0};
      for (int i = 0; i < LANES; i++)
         if (got[i] !== want.kept[i])
            report_mismatch($sformatf("result %0d kept_%0d: got %h expected %h",
                                      results_checked, i, got[i], want.kept[i]));
      if (rsp_kept_count !== want.count)
         report_mismatch($sformatf("result %0d kept_count: got %0d expected %0d",
                                   results_checked, rsp_kept_count, want.count));
      results_checked++;
   endtask

   // driver: a new word goes out only once the current one was taken
   always @(negedge clock) begin : drive_requests
      group_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || word_taken) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap--;
            end else if (pending_groups.size() != 0) begin
               nxt = pending_groups.pop_front();
               req_value_0        <= nxt.value[0];
               req_value_1        <= nxt.value[1];
               req_value_2        <= nxt.value[2];
               req_value_3        <= nxt.value[3];
               req_value_4        <= nxt.value[4];
               req_value_5        <= nxt.value[5];
               req_value_6        <= nxt.value[6];
               req_value_7        <= nxt.value[7];
               req_lane_count     <= nxt.lane_count;
               req_start_of_array <= nxt.start;
               req_valid          <= 1'b1;
               req_gap = pick_gap(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (!rsp_calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = pick_gap(1'b0);
         end else begin
            rsp_stall <= 1'b0;
         end
         // switch between idling and stretches with none
         if ($urandom_range(0, 249) == 0)
            req_calm = !req_calm;
         if ($urandom_range(0, 249) == 0)
            rsp_calm = !rsp_calm;
      end
   end

   // monitor: predicts on every accepted word, checks every accepted result
   always @(posedge clock) begin : watch_channels
      bit result_taken;
      if (reset) begin
         word_taken  = 1'b0;
         idle_cycles = 0;
      end else begin
         word_taken   = req_valid && !req_stall;
         result_taken = rsp_valid && !rsp_stall;
         if (result_taken)
            check_result();
         if (word_taken) begin
            if (req_lane_count == 0)
               empty_groups++;
            if (req_lane_count > LANES)
               saturated_groups++;
            due_compactions.push_back(compact_group('{
               {req_value_7, req_value_6, req_value_5, req_value_4,
                req_value_3, req_value_2, req_value_1, req_value_0},
               req_lane_count, req_start_of_array}));
            groups_accepted++;
         end
         idle_cycles = (word_taken || result_taken) ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      rsp_stall          = 1'b0;
      req_value_0        = '0;
      req_value_1        = '0;
      req_value_2        = '0;
      req_value_3        = '0;
      req_value_4        = '0;
      req_value_5        = '0;
      req_value_6        = '0;
      req_value_7        = '0;
      req_lane_count     = '0;
      req_start_of_array = 1'b0;

      // no predecessor yet: lane 0 kept although it matches the reset history
      queue_group({8{32'h0000_0000}}, 8, 1'b0);
      // lane 0 equal to the previous last value is dropped
      queue_group({32'hFFFF_FFFF, 32'h3, 32'h2, 32'h2, 32'h2, 32'h1, 32'h1, 32'h0}, 8, 1'b0);
      // start of array keeps lane 0 even when it repeats
      queue_group({8{32'hFFFF_FFFF}}, 8, 1'b1);
      // empty group leaves the history alone
      queue_group({8{32'h1234_5678}}, 0, 1'b1);
      // lanes past the count are ignored
      queue_group({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h5, 32'h5, 32'hFFFF_FFFF}, 3, 1'b0);
      // counts above eight saturate
      queue_group({4{32'h5A5A_5A5A, 32'hA5A5_A5A5}}, 15, 1'b0);
      queue_group({32'h0100_0000, 32'h0200_0000, 32'h0400_0000, 32'h0800_0000,
                   32'h1000_0000, 32'h2000_0000, 32'h4000_0000, 32'h8000_0000}, 9, 1'b0);
      queue_group({{7{32'hDEAD_BEEF}}, 32'h0100_0000}, 1, 1'b0);
      queue_group({{4{32'hC}}, 32'hC, 32'hB, 32'hB, 32'hA}, 4, 1'b1);
      queue_group({32'hF, 32'hF, 32'hE, 32'hE, 32'hD, 32'hD, 32'hC, 32'hC}, 8, 1'b0);
      queue_group({8{32'h0000_00F0}}, 0, 1'b0);
      // every valid lane a duplicate: zero kept but history still moves
      queue_group({{6{32'h7}}, 32'hF, 32'hF}, 2, 1'b0);
      queue_group({32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFE,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'hFFFF_FFFF}, 8, 1'b1);
      queue_group({8{32'hFFFF_FFFF}}, 8, 1'b0);

      while (groups_queued < RANDOM_GROUPS + 14) begin
         if ($urandom_range(0, 4) != 0)
            queue_sorted_run();
         else
            queue_noise_group();
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (groups_accepted < groups_queued || due_compactions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d word groups (%0d empty, %0d over-length), %0d results checked",
               groups_accepted, empty_groups, saturated_groups, results_checked);
      $display("%0d duplicate values removed across the run", duplicates_removed);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
